// File: sv/osq_pkg.sv
// shared types and constants for the ordered sequence table
package osq_pkg;

	localparam int OSQ_CAPACITY   = 64;
	localparam int OSQ_DATA_WIDTH = 32;

	// operation codes carried by an input beat
	typedef enum logic [2:0] {
		OP_INSERT_AT     = 3'd0,
		OP_INSERT_SORTED = 3'd1,
		OP_ERASE_AT      = 3'd2,
		OP_REMOVE_ALL    = 3'd3,
		OP_GET           = 3'd4,
		OP_SET           = 3'd5,
		OP_FIND          = 3'd6
	} op_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// per-cycle command from the sequencer to every cell
	typedef struct packed {
		logic shift;
		logic load;
	} osq_step_t;

endpackage

// File: sv/osq_cell.sv
// one storage cell of the entry chain
module osq_cell #(
	parameter int DATA_WIDTH = osq_pkg::OSQ_DATA_WIDTH,
	parameter int ADDR_W     = $clog2(osq_pkg::OSQ_CAPACITY),
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  osq_pkg::osq_step_t    step,
	input  logic [ADDR_W-1:0]     tgt,
	input  logic [DATA_WIDTH-1:0] inj_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic [DATA_WIDTH-1:0] data
);
	import osq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit;

	// this cell takes the injected entry when the write slot points here
	assign hit = step.load && (tgt == ADDR_W'(INDEX));

	// shift toward the head, or take the injected entry
	always_ff @(posedge clk) begin
		if (step.shift) begin
			data_q <= hit ? inj_data : next_data;
		end
	end

	assign data = data_q;

endmodule

// File: sv/osq_ctrl.sv
// sequencer: walks the chain head once per beat and rebuilds the list
module osq_ctrl #(
	parameter int CAPACITY   = osq_pkg::OSQ_CAPACITY,
	parameter int DATA_WIDTH = osq_pkg::OSQ_DATA_WIDTH,
	parameter int ADDR_W     = $clog2(CAPACITY),
	parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            op,
	input  logic [CNT_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] head,
	output logic                  busy,
	output logic                  done,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [CNT_W-1:0]      position_result,
	output logic [CNT_W-1:0]      length_now,
	output osq_pkg::osq_step_t    step,
	output logic [ADDR_W-1:0]     tgt,
	output logic [DATA_WIDTH-1:0] inj_data
);
	import osq_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_K = ADDR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);

	state_t state_q, state_n;

	// control state
	logic [CNT_W-1:0]      count_q;
	logic                  done_q;

	// per-beat working registers
	op_t                   op_q;
	logic [CNT_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  opok_q;
	logic [ADDR_W-1:0]     k_q;
	logic [ADDR_W-1:0]     tgt_q;
	logic [CNT_W-1:0]      w_q;
	logic                  placed_q;
	logic [DATA_WIDTH-1:0] hold_q;
	logic                  hold_v_q;
	logic [CNT_W-1:0]      ins_k_q;
	logic [CNT_W-1:0]      rm_q;
	logic                  found_q;
	logic [CNT_W-1:0]      find_k_q;
	logic [DATA_WIDTH-1:0] rd_q;

	// result registers
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic [CNT_W-1:0]      pres_q;

	// step decode
	logic                  accept;
	logic                  last;
	logic                  acc_ok;
	logic [CNT_W-1:0]      k_ext;
	logic                  live;
	logic                  ins_here;
	logic                  drop;
	logic                  emit;
	logic [DATA_WIDTH-1:0] emit_data;
	logic [CNT_W-1:0]      w_n;
	logic [CNT_W-1:0]      ins_k_n;
	logic [CNT_W-1:0]      rm_n;
	logic                  found_n;
	logic [CNT_W-1:0]      find_k_n;
	logic [DATA_WIDTH-1:0] rd_n;
	logic                  res_ok;
	logic [CNT_W-1:0]      res_pos;

	assign accept = start && (state_q == ST_IDLE);
	assign last   = (state_q == ST_SCAN) && (k_q == LAST_K);
	assign k_ext  = CNT_W'(k_q);
	assign live   = k_ext < count_q;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_n = ST_SCAN;
			end
			ST_SCAN: begin
				if (k_q == LAST_K) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy       = 1'b0;
		step.shift = 1'b0;
		step.load  = emit;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				step.shift = 1'b0;
			end
			ST_SCAN: begin
				busy       = 1'b1;
				step.shift = 1'b1;
			end
			default: begin
				busy       = 1'b0;
				step.shift = 1'b0;
			end
		endcase
	end

	// legality of the incoming beat against the current length
	always_comb begin
		case (op_t'(op))
			OP_INSERT_AT:     acc_ok = (count_q < CAP_C) && (position <= count_q);
			OP_INSERT_SORTED: acc_ok = (count_q < CAP_C);
			OP_ERASE_AT:      acc_ok = (position < count_q);
			OP_GET:           acc_ok = (position < count_q);
			OP_SET:           acc_ok = (position < count_q);
			OP_REMOVE_ALL:    acc_ok = 1'b1;
			default:          acc_ok = 1'b0;
		endcase
	end

	// what the head turns into this cycle
	always_comb begin
		ins_here  = 1'b0;
		drop      = 1'b0;
		emit      = live;
		emit_data = head;
		case (op_q) inside
			OP_INSERT_AT, OP_INSERT_SORTED: begin
				if (opok_q && !placed_q) begin
					if (op_q == OP_INSERT_AT) begin
						ins_here = (k_ext == pos_q);
					end else begin
						ins_here = (k_ext == count_q) || (live && (head >= val_q));
					end
				end
				if (ins_here) begin
					emit      = 1'b1;
					emit_data = val_q;
				end else if (placed_q) begin
					emit      = hold_v_q;
					emit_data = hold_q;
				end
			end
			OP_ERASE_AT: begin
				emit = live && (k_ext != pos_q);
			end
			OP_REMOVE_ALL: begin
				drop = live && (head == val_q);
				emit = live && !drop;
			end
			OP_SET: begin
				if (k_ext == pos_q) emit_data = val_q;
			end
			default: begin
				emit = live;
			end
		endcase
	end

	// running tallies including the current head
	always_comb begin
		w_n      = w_q + CNT_W'(emit);
		ins_k_n  = ins_here ? k_ext : ins_k_q;
		rm_n     = rm_q + CNT_W'(drop);
		found_n  = found_q;
		find_k_n = find_k_q;
		rd_n     = rd_q;
		if ((op_q == OP_FIND) && live && !found_q && (head == val_q)) begin
			found_n  = 1'b1;
			find_k_n = k_ext;
		end
		if ((op_q == OP_GET) && live && (k_ext == pos_q)) begin
			rd_n = head;
		end
	end

	// result fields at the end of the walk
	always_comb begin
		res_ok  = 1'b0;
		res_pos = '0;
		case (op_q)
			OP_INSERT_AT:     res_ok = opok_q;
			OP_INSERT_SORTED: begin
				res_ok  = opok_q;
				res_pos = ins_k_n;
			end
			OP_ERASE_AT:      res_ok = opok_q;
			OP_SET:           res_ok = opok_q;
			OP_GET:           res_ok = opok_q;
			OP_REMOVE_ALL: begin
				res_ok  = 1'b1;
				res_pos = rm_n;
			end
			OP_FIND: begin
				res_ok  = found_n;
				res_pos = find_k_n;
			end
			default:          res_ok = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= last;
			if (last) count_q <= w_n;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(op);
			pos_q    <= position;
			val_q    <= value;
			opok_q   <= acc_ok;
			k_q      <= '0;
			tgt_q    <= LAST_K;
			w_q      <= '0;
			placed_q <= 1'b0;
			hold_v_q <= 1'b0;
			ins_k_q  <= '0;
			rm_q     <= '0;
			found_q  <= 1'b0;
			find_k_q <= '0;
			rd_q     <= '0;
		end else if (state_q == ST_SCAN) begin
			k_q      <= k_q + ADDR_W'(1);
			tgt_q    <= emit ? tgt_q : tgt_q - ADDR_W'(1);
			w_q      <= w_n;
			placed_q <= placed_q || ins_here;
			hold_q   <= head;
			hold_v_q <= live;
			ins_k_q  <= ins_k_n;
			rm_q     <= rm_n;
			found_q  <= found_n;
			find_k_q <= find_k_n;
			rd_q     <= rd_n;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (last) begin
			ok_q         <= res_ok;
			read_value_q <= (op_q == OP_GET && res_ok) ? rd_n : '0;
			pres_q       <= res_ok ? res_pos : '0;
		end
	end

	assign tgt             = tgt_q;
	assign inj_data        = emit_data;
	assign done            = done_q;
	assign ok              = ok_q;
	assign read_value      = read_value_q;
	assign position_result = pres_q;
	assign length_now      = count_q;

endmodule

// File: sv/ordered_sequence_table.sv
// Ordered sequence table: a chain of cells rotated past a sequencer once per beat.
// A new beat is not taken while the walk is busy; start is taken again in the done cycle.
// The walk length is set by the chain depth: every beat shifts all CAPACITY cells on each step.
// Results are valid under done and held until the next walk ends; the receiver cannot stall.
// Reset clears the length to zero; cell contents are not reset.
module ordered_sequence_table #(
	parameter int CAPACITY   = osq_pkg::OSQ_CAPACITY,
	parameter int DATA_WIDTH = osq_pkg::OSQ_DATA_WIDTH,
	parameter int ADDR_W     = $clog2(CAPACITY),
	parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            op,
	input  logic [CNT_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  done,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [CNT_W-1:0]      position_result,
	output logic [CNT_W-1:0]      length_now
);
	import osq_pkg::*;

	osq_step_t             step;
	logic [ADDR_W-1:0]     tgt;
	logic [DATA_WIDTH-1:0] inj_data;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	// sequencer
	osq_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.op              (op),
		.position        (position),
		.value           (value),
		.head            (cell_data[0]),
		.busy            (busy),
		.done            (done),
		.ok              (ok),
		.read_value      (read_value),
		.position_result (position_result),
		.length_now      (length_now),
		.step            (step),
		.tgt             (tgt),
		.inj_data        (inj_data)
	);

	// chain of cells, each fed by its upper neighbor; the tail cell is fed by the injected entry
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] next_data;
		if (i == CAPACITY - 1) begin : g_tail
			assign next_data = inj_data;
		end else begin : g_body
			assign next_data = cell_data[i+1];
		end
		osq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.ADDR_W     (ADDR_W),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.step      (step),
			.tgt       (tgt),
			.inj_data  (inj_data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

endmodule

// File: tb/tb_top.sv
// testbench for the ordered sequence table: directed table, then random beats against a predictor
module tb_top;
	import osq_pkg::*;

	localparam int CAP            = OSQ_CAPACITY;
	localparam int DW             = OSQ_DATA_WIDTH;
	localparam int CNT_W          = $clog2(CAP + 1);
	localparam int WATCHDOG_LIMIT = 20 * (CAP + 1);
	localparam int PHASE_BEATS    = 475;
	localparam int N_DIR          = 25;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// one result beat
	typedef struct packed {
		logic             ok;
		logic [DW-1:0]    read_value;
		logic [CNT_W-1:0] position_result;
		logic [CNT_W-1:0] length_now;
	} outcome_t;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [2:0]       op;
		logic [CNT_W-1:0] position;
		logic [DW-1:0]    value;
		logic             typed;
		outcome_t         res;
	} stim_row_t;

	localparam outcome_t NO_RES = '0;

	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		{OP_GET,           7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0, 7'd0},
		{OP_ERASE_AT,      7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0, 7'd0},
		{OP_FIND,          7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0, 7'd0},
		{OP_REMOVE_ALL,    7'd0,   32'h0000_0005, 1'b1, 1'b1, 32'h0, 7'd0, 7'd0},
		{OP_INSERT_AT,     7'd1,   32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0, 7'd0},
		{OP_INSERT_AT,     7'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd0, 7'd1},
		{OP_INSERT_SORTED, 7'd127, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0, 7'd2},
		{OP_INSERT_SORTED, 7'd0,   32'h8000_0000, 1'b0, NO_RES},
		{OP_INSERT_AT,     7'd3,   32'h0000_0001, 1'b0, NO_RES},
		{OP_GET,           7'd3,   32'h0000_0000, 1'b0, NO_RES},
		{OP_GET,           7'd127, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0, 7'd4},
		{OP_SET,           7'd1,   32'hAAAA_AAAA, 1'b0, NO_RES},
		{OP_FIND,          7'd0,   32'hAAAA_AAAA, 1'b0, NO_RES},
		{OP_SET,           7'd64,  32'h5555_5555, 1'b0, NO_RES},
		{OP_UNUSED,        7'd127, 32'hFFFF_FFFF, 1'b0, NO_RES},
		{OP_INSERT_AT,     7'd0,   32'h0000_0001, 1'b0, NO_RES},
		{OP_INSERT_SORTED, 7'd0,   32'h0000_0001, 1'b0, NO_RES},
		{OP_REMOVE_ALL,    7'd0,   32'h0000_0001, 1'b0, NO_RES},
		{OP_FIND,          7'd0,   32'h0000_0001, 1'b0, NO_RES},
		{OP_ERASE_AT,      7'd2,   32'h0000_0000, 1'b0, NO_RES},
		{OP_ERASE_AT,      7'd2,   32'h0000_0000, 1'b0, NO_RES},
		{OP_ERASE_AT,      7'd0,   32'h0000_0000, 1'b0, NO_RES},
		{OP_INSERT_SORTED, 7'd0,   32'hFFFF_FFFF, 1'b0, NO_RES},
		{OP_GET,           7'd0,   32'h0000_0000, 1'b0, NO_RES},
		{OP_REMOVE_ALL,    7'd0,   32'h0000_0000, 1'b0, NO_RES}
	};

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             start    = 1'b0;
	logic [2:0]       op       = '0;
	logic [CNT_W-1:0] position = '0;
	logic [DW-1:0]    value    = '0;
	logic             busy;
	logic             done;
	logic             ok;
	logic [DW-1:0]    read_value;
	logic [CNT_W-1:0] position_result;
	logic [CNT_W-1:0] length_now;

	// predictor copy of the table
	logic [DW-1:0] tbl_entries [CAP];
	int            tbl_len = 0;

	outcome_t pending_outcomes [$];
	outcome_t oldest;
	int       mismatch_count  = 0;
	int       sender_idle_pct = 9;
	int       idle_cycles     = 0;
	bit       growing         = 1'b1;

	always #1 clk = ~clk;

	ordered_sequence_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.position        (position),
		.value           (value),
		.done            (done),
		.ok              (ok),
		.read_value      (read_value),
		.position_result (position_result),
		.length_now      (length_now)
	);

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("tb_top: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// apply one beat to the predictor table and return the result it gives
	function automatic outcome_t table_apply(input logic [2:0] o, input logic [CNT_W-1:0] p,
			input logic [DW-1:0] v);
		outcome_t r;
		int       k;
		int       w;
		r = '0;
		case (o)
			OP_INSERT_AT: begin
				if (p <= tbl_len && tbl_len < CAP) begin
					for (k = tbl_len; k > p; k--) tbl_entries[k] = tbl_entries[k - 1];
					tbl_entries[p] = v;
					tbl_len++;
					r.ok = 1'b1;
				end
			end
			OP_INSERT_SORTED: begin
				if (tbl_len < CAP) begin
					for (w = 0; w < tbl_len && tbl_entries[w] < v; w++) ;
					for (k = tbl_len; k > w; k--) tbl_entries[k] = tbl_entries[k - 1];
					tbl_entries[w] = v;
					tbl_len++;
					r.ok = 1'b1;
					r.position_result = CNT_W'(w);
				end
			end
			OP_ERASE_AT: begin
				if (p < tbl_len) begin
					for (k = p; k + 1 < tbl_len; k++) tbl_entries[k] = tbl_entries[k + 1];
					tbl_len--;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE_ALL: begin
				w = 0;
				for (k = 0; k < tbl_len; k++) begin
					if (tbl_entries[k] == v) begin
						r.position_result++;
					end else begin
						tbl_entries[w] = tbl_entries[k];
						w++;
					end
				end
				tbl_len = w;
				r.ok = 1'b1;
			end
			OP_GET: begin
				if (p < tbl_len) begin
					r.read_value = tbl_entries[p];
					r.ok = 1'b1;
				end
			end
			OP_SET: begin
				if (p < tbl_len) begin
					tbl_entries[p] = v;
					r.ok = 1'b1;
				end
			end
			OP_FIND: begin
				for (k = 0; k < tbl_len; k++) begin
					if (!r.ok && tbl_entries[k] == v) begin
						r.ok = 1'b1;
						r.position_result = CNT_W'(k);
					end
				end
			end
			default: ;
		endcase
		r.length_now = CNT_W'(tbl_len);
		return r;
	endfunction

	// values that collide often, plus extremes and full-range noise
	function automatic logic [DW-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return DW'($urandom_range(0, 7));
		if (r < 7 && tbl_len > 0) return tbl_entries[$urandom_range(0, tbl_len - 1)];
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return '1;
				2: return {1'b1, {(DW - 1){1'b0}}};
				default: return {1'b0, {(DW - 1){1'b1}}};
			endcase
		end
		return DW'($urandom());
	endfunction

	// drive one beat, optionally after a gap or a full drain, and wait until it is taken
	task automatic send_beat(input logic [2:0] o, input logic [CNT_W-1:0] p,
			input logic [DW-1:0] v, input logic typed, input outcome_t typed_res,
			input bit drain);
		outcome_t predicted;
		if (drain && pending_outcomes.size() != 0) begin
			start <= 1'b0;
			while (pending_outcomes.size() != 0) @(posedge clk);
		end else if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, CAP + 6)) @(posedge clk);
		end
		start    <= 1'b1;
		op       <= o;
		position <= p;
		value    <= v;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = table_apply(o, p, v);
		pending_outcomes.push_back(typed ? typed_res : predicted);
	endtask

	// random beat; op mix leans toward growing or shrinking the table
	task automatic random_beat();
		int               w [8];
		int               r;
		int               k;
		logic [CNT_W-1:0] p;
		if (tbl_len == CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
		else if (tbl_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
		else if ($urandom_range(0, 199) == 0) growing = !growing;
		if (growing) w = '{35, 30, 5, 2, 10, 8, 8, 2};
		else w = '{10, 10, 30, 10, 12, 10, 16, 2};
		r = $urandom_range(0, 99);
		for (k = 0; k < 7; k++) begin
			if (r < w[k]) break;
			r -= w[k];
		end
		r = $urandom_range(0, 9);
		if (r < 8) p = CNT_W'($urandom_range(0, tbl_len));
		else if (r == 8) p = CNT_W'($urandom_range(0, 127));
		else p = CNT_W'(tbl_len);
		send_beat(k[2:0], p, pick_value(), 1'b0, NO_RES, $urandom_range(0, 59) == 0);
	endtask

	// result checker: every strobed beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with nothing expected", read_value, '0);
			end else begin
				oldest = pending_outcomes.pop_front();
				if (ok !== oldest.ok) report_mismatch("ok", DW'(ok), DW'(oldest.ok));
				if (read_value !== oldest.read_value)
					report_mismatch("read_value", read_value, oldest.read_value);
				if (position_result !== oldest.position_result)
					report_mismatch("position_result", DW'(position_result),
						DW'(oldest.position_result));
				if (length_now !== oldest.length_now)
					report_mismatch("length_now", DW'(length_now), DW'(oldest.length_now));
			end
		end
	end

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		int i;
		int ph;
		for (i = 0; i < CAP; i++) tbl_entries[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (i = 0; i < N_DIR; i++) begin
			send_beat(DIR_ROWS[i].op, DIR_ROWS[i].position, DIR_ROWS[i].value,
				DIR_ROWS[i].typed, DIR_ROWS[i].res, 1'b0);
		end

		// random phases: sender idles rarely, then often, then never
		for (ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 57 : 0;
			// fill to capacity after a drain, then push into the full table
			send_beat(OP_INSERT_SORTED, CNT_W'($urandom_range(0, 127)), pick_value(), 1'b0,
				NO_RES, 1'b1);
			while (tbl_len < CAP)
				send_beat(OP_INSERT_SORTED, CNT_W'($urandom_range(0, 127)), pick_value(), 1'b0,
					NO_RES, 1'b0);
			for (i = 0; i < 3; i++)
				send_beat(i[0] ? OP_INSERT_SORTED : OP_INSERT_AT,
					CNT_W'($urandom_range(0, CAP)), pick_value(), 1'b0, NO_RES, 1'b0);
			for (i = 0; i < PHASE_BEATS - CAP; i++) random_beat();
		end

		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (CAP + 5) @(posedge clk);
		if (mismatch_count == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/osq_pkg.sv
sv/osq_cell.sv
sv/osq_ctrl.sv
sv/ordered_sequence_table.sv
tb/tb_top.sv
